FILE: hdl/nru_pkg.sv
package nru_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LIMIT_W    = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Register index, taken from paddr[2]
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    // Statistics counters
    localparam int STAT_W = 32;
    localparam logic [STAT_W-1:0] STAT_MAX = '1;

    // NRU classes, lowest first; the last one takes any resident entry
    localparam int NUM_CLASSES = 4;
    localparam logic [1:0] CLASS_R0_M0 = 2'd0;
    localparam logic [1:0] CLASS_R0_M1 = 2'd1;
    localparam logic [1:0] CLASS_R1_M0 = 2'd2;
    localparam logic [1:0] CLASS_ANY   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } nru_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } nru_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_addr;
        logic out_free;
    } nru_sts_t;

endpackage

FILE: hdl/nru_ctrl.sv
module nru_ctrl
    import nru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  nru_sts_t sts,
    output nru_cmd_t cmd
);

    nru_state_t state_reg;
    nru_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one reference: take it, sweep the table, settle, commit
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/nru_datapath.sv
module nru_datapath
    import nru_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 20,
    parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int OUT_W     = ((2 + IDX_W + PAGE_BITS + 2 * STAT_W + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nru_cmd_t             cmd,
    output nru_sts_t             sts,
    input  logic                 in_opcode,
    input  logic [PAGE_BITS-1:0] in_page,
    input  logic [LIMIT_W-1:0]   frames_in_use,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata
);

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int ORD_W = IDX_W;
    localparam int CMP_W = (IDX_W + 1 > LIMIT_W) ? IDX_W + 1 : LIMIT_W;
    localparam int RAW_W = 2 + IDX_W + PAGE_BITS + 2 * STAT_W;

    // Page table memory, one read port used by the sweep
    logic [PAGE_BITS-1:0] page_mem [FRAMES];

    // Per-frame status in flip-flops
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FRAMES-1:0] ref_reg, ref_next;
    logic [FRAMES-1:0] mod_reg, mod_next;
    logic [ORD_W-1:0]  order_reg [FRAMES];
    logic [ORD_W-1:0]  order_next [FRAMES];

    logic [CNT_W-1:0]  rc_reg, rc_next;
    logic [STAT_W-1:0] fault_reg, fault_next;
    logic [STAT_W-1:0] refc_reg, refc_next;

    // Latched reference
    logic                 op_reg;
    logic [PAGE_BITS-1:0] page_reg;

    // Sweep pipeline
    logic [IDX_W-1:0]     scan_idx_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [PAGE_BITS-1:0] rd_page_reg;

    // Search results
    logic                 hit_fnd_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic                 free_fnd_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 cls_fnd_reg  [NUM_CLASSES];
    logic [IDX_W-1:0]     cls_idx_reg  [NUM_CLASSES];
    logic [ORD_W-1:0]     cls_ord_reg  [NUM_CLASSES];
    logic [PAGE_BITS-1:0] cls_page_reg [NUM_CLASSES];

    // Output register
    logic             out_vld_reg, out_vld_next;
    logic [RAW_W-1:0] out_data_reg, out_data_next;

    // Entry under evaluation
    logic             e_v, e_r, e_m;
    logic [ORD_W-1:0] e_o;
    logic             e_in_lim;
    logic             cls_match [NUM_CLASSES];

    // Commit
    logic [1:0]           vic_cls;
    logic [IDX_W-1:0]     vic_idx;
    logic [ORD_W-1:0]     vic_ord;
    logic [PAGE_BITS-1:0] vic_page;
    logic                 evict;
    logic [IDX_W-1:0]     tgt_idx;
    logic [CNT_W-1:0]     rc_dec;
    logic                 mem_we;

    assign sts.last_addr = (scan_idx_reg == IDX_W'(FRAMES - 1));
    assign sts.out_free  = !out_vld_reg || m_tready;
    assign m_tvalid      = out_vld_reg;
    assign m_tdata       = OUT_W'(out_data_reg);

    // Read the entry status for the swept frame
    always_comb
    begin
        e_v = valid_reg[rd_idx_reg];
        e_r = ref_reg[rd_idx_reg];
        e_m = mod_reg[rd_idx_reg];
        e_o = order_reg[rd_idx_reg];
        // A limit of zero behaves as one
        e_in_lim = (rd_idx_reg == '0)
                   || (CMP_W'(rd_idx_reg) < CMP_W'(frames_in_use));
        cls_match[CLASS_R0_M0] = !e_r && !e_m;
        cls_match[CLASS_R0_M1] = !e_r && e_m;
        cls_match[CLASS_R1_M0] = e_r && !e_m;
        cls_match[CLASS_ANY]   = 1'b1;
    end

    // Latch the reference and advance the sweep
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= in_opcode;
            page_reg <= in_page;
        end
        rd_idx_reg  <= scan_idx_reg;
        rd_page_reg <= page_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    // Accumulate hit, lowest free frame and oldest entry of each class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_fnd_reg  <= 1'b0;
            free_fnd_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cls_fnd_reg[c] <= 1'b0;
            end
        end
        else if (cmd.start)
        begin
            hit_fnd_reg  <= 1'b0;
            free_fnd_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cls_fnd_reg[c] <= 1'b0;
            end
        end
        else if (rd_vld_reg)
        begin
            if (e_v && (rd_page_reg == page_reg) && !hit_fnd_reg)
            begin
                hit_fnd_reg <= 1'b1;
            end
            if (!e_v && e_in_lim && !free_fnd_reg)
            begin
                free_fnd_reg <= 1'b1;
            end
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (e_v && cls_match[c] && (!cls_fnd_reg[c] || (e_o < cls_ord_reg[c])))
                begin
                    cls_fnd_reg[c] <= 1'b1;
                end
            end
        end
    end

    // Index and page fields of the search results
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (e_v && (rd_page_reg == page_reg) && !hit_fnd_reg)
            begin
                hit_idx_reg <= rd_idx_reg;
            end
            if (!e_v && e_in_lim && !free_fnd_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (e_v && cls_match[c] && (!cls_fnd_reg[c] || (e_o < cls_ord_reg[c])))
                begin
                    cls_idx_reg[c]  <= rd_idx_reg;
                    cls_ord_reg[c]  <= e_o;
                    cls_page_reg[c] <= rd_page_reg;
                end
            end
        end
    end

    // Pick the victim from the lowest populated class
    always_comb
    begin
        priority if (cls_fnd_reg[CLASS_R0_M0])
        begin
            vic_cls = CLASS_R0_M0;
        end
        else if (cls_fnd_reg[CLASS_R0_M1])
        begin
            vic_cls = CLASS_R0_M1;
        end
        else if (cls_fnd_reg[CLASS_R1_M0])
        begin
            vic_cls = CLASS_R1_M0;
        end
        else
        begin
            vic_cls = CLASS_ANY;
        end
        vic_idx  = cls_idx_reg[vic_cls];
        vic_ord  = cls_ord_reg[vic_cls];
        vic_page = cls_page_reg[vic_cls];
    end

    // Work out the table update and the result
    always_comb
    begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        mod_next   = mod_reg;
        order_next = order_reg;
        rc_next    = rc_reg;
        fault_next = fault_reg;
        refc_next  = refc_reg;
        rc_dec     = rc_reg - CNT_W'(1);
        evict      = !hit_fnd_reg && !free_fnd_reg;
        mem_we     = 1'b0;

        priority if (hit_fnd_reg)
        begin
            tgt_idx = hit_idx_reg;
        end
        else if (free_fnd_reg)
        begin
            tgt_idx = free_idx_reg;
        end
        else
        begin
            tgt_idx = vic_idx;
        end

        if (cmd.commit)
        begin
            if (refc_reg != STAT_MAX)
            begin
                refc_next = refc_reg + STAT_W'(1);
            end
            if (hit_fnd_reg)
            begin
                ref_next[tgt_idx] = 1'b1;
                if (op_reg)
                begin
                    mod_next[tgt_idx] = 1'b1;
                end
            end
            else
            begin
                mem_we = 1'b1;
                if (fault_reg != STAT_MAX)
                begin
                    fault_next = fault_reg + STAT_W'(1);
                end
                if (free_fnd_reg)
                begin
                    valid_next[tgt_idx] = 1'b1;
                    order_next[tgt_idx] = rc_reg[ORD_W-1:0];
                    rc_next             = rc_reg + CNT_W'(1);
                end
                else
                begin
                    // Clear every referenced bit and close the gap in load order
                    ref_next = '0;
                    for (int i = 0; i < FRAMES; i++)
                    begin
                        if (valid_reg[i] && (order_reg[i] > vic_ord))
                        begin
                            order_next[i] = order_reg[i] - ORD_W'(1);
                        end
                    end
                    if (rc_reg == '0)
                    begin
                        order_next[tgt_idx] = '0;
                        rc_next             = CNT_W'(1);
                    end
                    else
                    begin
                        order_next[tgt_idx] = rc_dec[ORD_W-1:0];
                    end
                end
                ref_next[tgt_idx] = 1'b1;
                mod_next[tgt_idx] = op_reg;
            end
        end

        out_data_next = {refc_next, fault_next,
                         evict ? vic_page : {PAGE_BITS{1'b0}},
                         evict, tgt_idx, hit_fnd_reg};

        if (cmd.commit)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Hold frame status and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            ref_reg     <= '0;
            mod_reg     <= '0;
            rc_reg      <= '0;
            fault_reg   <= '0;
            refc_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            ref_reg     <= ref_next;
            mod_reg     <= mod_next;
            rc_reg      <= rc_next;
            fault_reg   <= fault_next;
            refc_reg    <= refc_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Load order and the result payload need no reset
    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
        if (cmd.commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Write the new page into the page table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[tgt_idx] <= page_reg;
        end
    end

endmodule

FILE: hdl/nru_page_replacement.sv
// Channel   Direction  Transaction
// s_*       in         one page reference: page number, read or write opcode
// m_*       out        one result: hit, frame, eviction, fault and reference totals
// apb       in/out     frames_in_use register at byte address 0
//
// Each reference is held from acceptance until its commit before the next one can
// be accepted; the sweep of the page table memory reads one frame per cycle
// through its single read port.
// Reset clears valid, referenced and modified bits and the counters at once;
// no clearing pass is run. A stalled result holds in the output register while
// the next reference is accepted; the commit waits only if that slot is full.
module nru_page_replacement
    import nru_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 20,
    localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int IN_W     = ((PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((2 + IDX_W + PAGE_BITS + 2 * STAT_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: page_number
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    // s_tuser: opcode
    input  logic                  s_tuser,
    // m_tdata: hit, frame_index, evicted, evicted_page, fault_count, reference_count
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               reg_sel;
    nru_cmd_t           cmd;
    nru_sts_t           sts;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_FRAMES_IN_USE);
    assign prdata  = reg_sel ? CFG_DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    nru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nru_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W),
        .OUT_W     (OUT_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_opcode     (s_tuser),
        .in_page       (s_tdata[PAGE_BITS-1:0]),
        .frames_in_use (limit_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import nru_pkg::*;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 20;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 96;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] ADDR_LIMIT = {REG_FRAMES_IN_USE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = {~REG_FRAMES_IN_USE, 2'b00};

    // Result transaction, hit in bit 0
    typedef struct packed {
        logic [5:0]           pad;
        logic [STAT_W-1:0]    refs;
        logic [STAT_W-1:0]    faults;
        logic [PAGE_BITS-1:0] evicted_page;
        logic                 evicted;
        logic [3:0]           frame;
        logic                 hit;
    } lookup_t;

    typedef enum logic [1:0] {
        ROW_REF,
        ROW_LIMIT,
        ROW_SPARE
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic                 op;
        logic [PAGE_BITS-1:0] value;
        bit                   typed;
        logic                 hit;
        logic [3:0]           frame;
        logic                 evicted;
        logic [PAGE_BITS-1:0] victim;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  s_tuser  = OP_READ;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the frame table
    logic                 f_valid [FRAMES];
    logic [PAGE_BITS-1:0] f_page  [FRAMES];
    logic                 f_ref   [FRAMES];
    logic                 f_mod   [FRAMES];
    int                   f_age   [FRAMES];
    int                   resident;
    logic [STAT_W-1:0]    faults_seen;
    logic [STAT_W-1:0]    refs_seen;
    logic [LIMIT_W-1:0]   limit_reg;

    lookup_t   awaited_lookups[$];
    stim_row_t rows[$];
    int        errors      = 0;
    int        hold_left   = 0;
    bit        calm        = 1'b0;
    int        n_results   = 0;
    int        n_hits      = 0;
    int        n_evictions = 0;

    nru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Work out the outcome of one reference and advance the shadow table
    function automatic lookup_t resolve_reference(logic op, logic [PAGE_BITS-1:0] page);
        lookup_t r;
        int      slot;
        int      lim;
        int      victim;
        r    = '0;
        slot = -1;
        if (refs_seen != STAT_MAX)
            refs_seen++;
        for (int i = 0; i < FRAMES; i++)
            if (slot < 0 && f_valid[i] && f_page[i] == page)
                slot = i;
        if (slot >= 0)
        begin
            r.hit       = 1'b1;
            f_ref[slot] = 1'b1;
            if (op == OP_WRITE)
                f_mod[slot] = 1'b1;
        end
        else
        begin
            lim = int'(limit_reg);
            if (lim < 1)
                lim = 1;
            if (lim > FRAMES)
                lim = FRAMES;
            if (faults_seen != STAT_MAX)
                faults_seen++;
            for (int i = 0; i < lim; i++)
                if (slot < 0 && !f_valid[i])
                    slot = i;
            if (slot < 0)
            begin
                // Lowest class first, oldest load within the class
                victim = -1;
                for (int c = 0; c < NUM_CLASSES && victim < 0; c++)
                    for (int i = 0; i < FRAMES; i++)
                        if (f_valid[i] && (c == CLASS_ANY || {f_ref[i], f_mod[i]} == c)
                            && (victim < 0 || f_age[i] < f_age[victim]))
                            victim = i;
                r.evicted      = 1'b1;
                r.evicted_page = f_page[victim];
                for (int i = 0; i < FRAMES; i++)
                begin
                    f_ref[i] = 1'b0;
                    if (f_valid[i] && f_age[i] > f_age[victim])
                        f_age[i]--;
                end
                f_valid[victim] = 1'b0;
                resident--;
                slot = victim;
            end
            f_valid[slot] = 1'b1;
            f_page[slot]  = page;
            f_ref[slot]   = 1'b1;
            f_mod[slot]   = op;
            f_age[slot]   = resident;
            resident++;
        end
        r.frame  = slot[3:0];
        r.faults = faults_seen;
        r.refs   = refs_seen;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    // Offer one reference and queue its outcome once accepted
    task automatic send_ref(logic op, logic [PAGE_BITS-1:0] page);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(IN_W-PAGE_BITS){1'b0}}, page};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        awaited_lookups.push_back(resolve_reference(op, page));
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 17)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
    endtask

    // Drop valid, let every outcome arrive, then let the block go quiet
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (awaited_lookups.size() != 0)
            @(posedge clk);
        repeat (FRAMES + 4) @(posedge clk);
    endtask

    // Register write followed by a readback of the frame limit
    task automatic write_limit(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr[2] == REG_FRAMES_IN_USE)
            limit_reg = data[LIMIT_W-1:0];
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_LIMIT;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[LIMIT_W-1:0] !== limit_reg)
            note_mismatch("frames_in_use readback", 32'(limit_reg), prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic add_row(row_kind_t kind, logic op, logic [PAGE_BITS-1:0] value, bit typed,
                           logic hit, logic [3:0] frame, logic evicted,
                           logic [PAGE_BITS-1:0] victim);
        stim_row_t r;
        r.kind    = kind;
        r.op      = op;
        r.value   = value;
        r.typed   = typed;
        r.hit     = hit;
        r.frame   = frame;
        r.evicted = evicted;
        r.victim  = victim;
        rows.push_back(r);
    endtask

    // Result side: idle at random, or hold off while a count runs down
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready = calm || ($urandom_range(99) >= 17);
    end

    // Compare each result transaction with the oldest outcome
    always @(posedge clk)
    begin : result_check
        lookup_t got;
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = lookup_t'(m_tdata);
            n_results++;
            if (got.hit)
                n_hits++;
            if (got.evicted)
                n_evictions++;
            if (awaited_lookups.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t result with nothing outstanding: %h", $time, m_tdata);
            end
            else
            begin
                want = awaited_lookups.pop_front();
                if (got.hit !== want.hit)
                    note_mismatch("hit", 32'(want.hit), 32'(got.hit));
                if (got.frame !== want.frame)
                    note_mismatch("frame_index", 32'(want.frame), 32'(got.frame));
                if (got.evicted !== want.evicted)
                    note_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
                if (got.evicted_page !== want.evicted_page)
                    note_mismatch("evicted_page", 32'(want.evicted_page),
                                  32'(got.evicted_page));
                if (got.faults !== want.faults)
                    note_mismatch("fault_count", want.faults, got.faults);
                if (got.refs !== want.refs)
                    note_mismatch("reference_count", want.refs, got.refs);
            end
        end
    end

    initial
    begin : stimulus
        int                   limits [8];
        int                   eff;
        logic [PAGE_BITS-1:0] pool[$];
        logic [PAGE_BITS-1:0] page;
        logic [CFG_DATA_W-1:0] word;
        int                   n;

        limits = '{16, 3, 0, 31, 1, 8, 16, 5};
        for (int i = 0; i < FRAMES; i++)
        begin
            f_valid[i] = 1'b0;
            f_ref[i]   = 1'b0;
            f_mod[i]   = 1'b0;
            f_page[i]  = '0;
            f_age[i]   = 0;
        end
        resident    = 0;
        faults_seen = '0;
        refs_seen   = '0;
        limit_reg   = LIMIT_RESET;

        // Fill from empty, hit both ways, then evict under a limit of zero
        add_row(ROW_REF,   OP_READ,  20'h00000, 1, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_WRITE, 20'hFFFFF, 1, 0, 4'd1, 0, 20'h0);
        add_row(ROW_REF,   OP_WRITE, 20'h00000, 1, 1, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_READ,  20'hFFFFF, 1, 1, 4'd1, 0, 20'h0);
        add_row(ROW_REF,   OP_READ,  20'h55555, 1, 0, 4'd2, 0, 20'h0);
        add_row(ROW_REF,   OP_WRITE, 20'hAAAAA, 1, 0, 4'd3, 0, 20'h0);
        add_row(ROW_LIMIT, OP_READ,  20'd0,     0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_READ,  20'h12345, 1, 0, 4'd2, 1, 20'h55555);
        add_row(ROW_REF,   OP_WRITE, 20'h0F0F0, 1, 0, 4'd0, 1, 20'h00000);
        add_row(ROW_REF,   OP_READ,  20'h0F0F0, 1, 1, 4'd0, 0, 20'h0);
        add_row(ROW_SPARE, OP_READ,  20'd5,     0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_WRITE, 20'h00000, 1, 0, 4'd2, 1, 20'h12345);
        // Out-of-range limit acts as the full table
        add_row(ROW_LIMIT, OP_READ,  20'd31,    0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_READ,  20'h00001, 1, 0, 4'd4, 0, 20'h0);
        add_row(ROW_REF,   OP_WRITE, 20'h80000, 1, 0, 4'd5, 0, 20'h0);
        // Limit of one with pages resident above it
        add_row(ROW_LIMIT, OP_READ,  20'd1,     0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_READ,  20'h7FFFF, 0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_WRITE, 20'h80000, 0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_WRITE, 20'h33333, 0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_LIMIT, OP_READ,  20'd16,    0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_READ,  20'hCCCCC, 0, 0, 4'd0, 0, 20'h0);
        add_row(ROW_REF,   OP_READ,  20'h7FFFF, 0, 0, 4'd0, 0, 20'h0);

        // Hold reset, then release it
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (rows[k])
        begin
            case (rows[k].kind)
                ROW_REF:
                begin
                    send_ref(rows[k].op, rows[k].value);
                    if (rows[k].typed)
                    begin
                        n = awaited_lookups.size() - 1;
                        awaited_lookups[n].hit          = rows[k].hit;
                        awaited_lookups[n].frame        = rows[k].frame;
                        awaited_lookups[n].evicted      = rows[k].evicted;
                        awaited_lookups[n].evicted_page = rows[k].victim;
                    end
                end
                ROW_LIMIT:
                begin
                    drain();
                    write_limit(ADDR_LIMIT, {12'd0, rows[k].value});
                end
                default:
                begin
                    drain();
                    write_limit(ADDR_SPARE, {12'd0, rows[k].value});
                end
            endcase
        end

        // Random phases, each under its own frame limit over a small working set
        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_limit(ADDR_SPARE, $urandom);
            word = $urandom;
            word[LIMIT_W-1:0] = limits[p][LIMIT_W-1:0];
            write_limit(ADDR_LIMIT, word);
            calm = (p == 5);
            eff  = (limits[p] < 1) ? 1 : (limits[p] > FRAMES) ? FRAMES : limits[p];
            pool.delete();
            n = eff + int'($urandom_range(1, 4));
            for (int i = 0; i < n; i++)
                pool.push_back(PAGE_BITS'($urandom));
            for (int k = 0; k < 120; k++)
            begin
                if (p == 1 && k == 10)
                    hold_left = 400;
                if (p == 2 && k == 60)
                begin
                    @(negedge clk);
                    s_tvalid = 1'b0;
                    while (awaited_lookups.size() != 0)
                        @(posedge clk);
                end
                if ($urandom_range(99) < 85)
                    page = pool[$urandom_range(pool.size() - 1)];
                else
                    page = PAGE_BITS'($urandom);
                send_ref(1'($urandom_range(1, 0)), page);
                maybe_idle();
            end
        end

        // Let the last outcomes arrive, then a short quiet spell
        @(negedge clk);
        s_tvalid = 1'b0;
        while (awaited_lookups.size() != 0)
            @(posedge clk);
        repeat (FRAMES + 10) @(posedge clk);

        $display("tb: %0d references checked, %0d hits, %0d evictions", n_results, n_hits,
                 n_evictions);
        $display("tb: frame limits 0 to 31, spare register, stalls on both sides");
        if (errors == 0 && awaited_lookups.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/nru_pkg.sv
hdl/nru_ctrl.sv
hdl/nru_datapath.sv
hdl/nru_page_replacement.sv
dv/tb.sv
